>>> sv/aidst_pkg.sv
// Shared constants and types of the active id dense set tracker.
package aidst_pkg;

   localparam int MAX_IDS = 1024;
   localparam int ID_W    = 10;
   localparam int CNT_W   = 11;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_SWEEP  = 1'b1;

   typedef struct packed {
      logic            kind;
      logic [ID_W-1:0] id;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0]  slot;
      logic             newly_active;
      logic [CNT_W-1:0] active_count;
      logic [CNT_W-1:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic            seen;
      logic [ID_W-1:0] rank;
   } rank_entry_type;

   typedef struct packed {
      logic            we;
      logic [ID_W-1:0] waddr;
      logic [ID_W-1:0] wdata;
      logic [ID_W-1:0] raddr;
   } slot_mem_req_type;

   typedef struct packed {
      logic            we;
      logic [ID_W-1:0] waddr;
      rank_entry_type  wdata;
      logic [ID_W-1:0] raddr;
   } rank_mem_req_type;

endpackage

>>> sv/active_id_dense_set_tracker.sv
// Top level of the active id dense set tracker: tables, sequencer and result register.
//
// After reset the block writes the identity permutation into both tables and
// accepts no item until that pass is done. Items are then handled one at a time
// through the two single-read-port tables. A report of an id that is already
// active goes from acceptance through an evaluate state to the result; one that
// moves the id into the active region passes a swap state too. An end-of-frame
// item visits each active slot in turn; each visit needs a slot read and a
// dependent seen/rank read, and an id swept out also needs the swap writes. The
// result waits in an output register, so the next item is taken while it is held.
module active_id_dense_set_tracker
   import aidst_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   slot_mem_req_type slot_req;
   rank_mem_req_type rank_req;
   logic [ID_W-1:0]  slot_rdata;
   rank_entry_type   rank_rdata;
   logic             done_valid;
   logic             done_ready;
   rsp_type          done_data;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;

   aidst_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_IDS)
   ) u_slot_ram (
      .clock (clock),
      .we    (slot_req.we),
      .waddr (slot_req.waddr),
      .wdata (slot_req.wdata),
      .raddr (slot_req.raddr),
      .rdata (slot_rdata)
   );

   aidst_ram #(
      .WIDTH ($bits(rank_entry_type)),
      .DEPTH (MAX_IDS)
   ) u_rank_ram (
      .clock (clock),
      .we    (rank_req.we),
      .waddr (rank_req.waddr),
      .wdata (rank_req.wdata),
      .raddr (rank_req.raddr),
      .rdata (rank_rdata)
   );

   aidst_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .slot_req   (slot_req),
      .slot_rdata (slot_rdata),
      .rank_req   (rank_req),
      .rank_rdata (rank_rdata),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data)
   );

   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_valid && done_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_valid && done_ready) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/aidst_ram.sv
// Generic single write port, single read port RAM with registered read data.
module aidst_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/aidst_seq.sv
// Sequencer: clearing pass, report update and end-of-frame sweep over the two tables.
module aidst_seq
   import aidst_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output slot_mem_req_type slot_req,
   input  logic [ID_W-1:0]  slot_rdata,
   output rank_mem_req_type rank_req,
   input  rank_entry_type   rank_rdata,
   output logic             done_valid,
   input  logic             done_ready,
   output rsp_type          done_data
);

   typedef enum logic [9:0] {
      ST_CLEAR    = 10'b0000000001,
      ST_IDLE     = 10'b0000000010,
      ST_RPT_EVAL = 10'b0000000100,
      ST_RPT_SWAP = 10'b0000001000,
      ST_SWP_CHK  = 10'b0000010000,
      ST_SWP_LOOK = 10'b0000100000,
      ST_SWP_EVAL = 10'b0001000000,
      ST_SWP_MOVE = 10'b0010000000,
      ST_SWP_FIX  = 10'b0100000000,
      ST_DONE     = 10'b1000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [ID_W-1:0]  ptr_ff, ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] removed_ff, removed_in;
   logic [ID_W-1:0]  id_ff, id_in;
   logic [ID_W-1:0]  cur_ff, cur_in;
   logic [ID_W-1:0]  last_ff, last_in;
   logic [ID_W-1:0]  res_slot_ff, res_slot_in;
   logic             res_newly_ff, res_newly_in;
   logic [CNT_W-1:0] count_dec;

   assign count_dec  = count_ff - CNT_W'(1);
   assign req_ready  = (state_ff == ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);

   always_comb begin
      done_data.slot          = res_slot_ff;
      done_data.newly_active  = res_newly_ff;
      done_data.active_count  = count_ff;
      done_data.removed_count = removed_ff;
   end

   always_comb begin
      state_in     = state_ff;
      ptr_in       = ptr_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      removed_in   = removed_ff;
      id_in        = id_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      res_slot_in  = res_slot_ff;
      res_newly_in = res_newly_ff;
      slot_req     = '0;
      rank_req     = '0;
      case (state_ff)
         ST_CLEAR: begin
            slot_req.we         = 1'b1;
            slot_req.waddr      = ptr_ff;
            slot_req.wdata      = ptr_ff;
            rank_req.we         = 1'b1;
            rank_req.waddr      = ptr_ff;
            rank_req.wdata.seen = 1'b0;
            rank_req.wdata.rank = ptr_ff;
            ptr_in              = ptr_ff + ID_W'(1);
            if (ptr_ff == ID_W'(MAX_IDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            slot_req.raddr = count_ff[ID_W-1:0];
            rank_req.raddr = req_data.id;
            if (req_valid) begin
               id_in        = req_data.id;
               removed_in   = '0;
               res_slot_in  = '0;
               res_newly_in = 1'b0;
               idx_in       = '0;
               if (req_data.kind == KIND_REPORT) begin
                  state_in = ST_RPT_EVAL;
               end else begin
                  state_in = ST_SWP_CHK;
               end
            end
         end
         ST_RPT_EVAL: begin
            if ({1'b0, rank_rdata.rank} >= count_ff && count_ff < CNT_W'(MAX_IDS)) begin
               slot_req.we         = 1'b1;
               slot_req.waddr      = rank_rdata.rank;
               slot_req.wdata      = slot_rdata;
               rank_req.we         = 1'b1;
               rank_req.waddr      = slot_rdata;
               rank_req.wdata.seen = 1'b0;
               rank_req.wdata.rank = rank_rdata.rank;
               state_in            = ST_RPT_SWAP;
            end else begin
               rank_req.we         = 1'b1;
               rank_req.waddr      = id_ff;
               rank_req.wdata.seen = 1'b1;
               rank_req.wdata.rank = rank_rdata.rank;
               res_slot_in         = rank_rdata.rank;
               state_in            = ST_DONE;
            end
         end
         ST_RPT_SWAP: begin
            slot_req.we         = 1'b1;
            slot_req.waddr      = count_ff[ID_W-1:0];
            slot_req.wdata      = id_ff;
            rank_req.we         = 1'b1;
            rank_req.waddr      = id_ff;
            rank_req.wdata.seen = 1'b1;
            rank_req.wdata.rank = count_ff[ID_W-1:0];
            res_slot_in         = count_ff[ID_W-1:0];
            res_newly_in        = 1'b1;
            count_in            = count_ff + CNT_W'(1);
            state_in            = ST_DONE;
         end
         ST_SWP_CHK: begin
            slot_req.raddr = idx_ff[ID_W-1:0];
            if (idx_ff < count_ff) begin
               state_in = ST_SWP_LOOK;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SWP_LOOK: begin
            cur_in         = slot_rdata;
            rank_req.raddr = slot_rdata;
            slot_req.raddr = count_dec[ID_W-1:0];
            state_in       = ST_SWP_EVAL;
         end
         ST_SWP_EVAL: begin
            if (rank_rdata.seen) begin
               rank_req.we         = 1'b1;
               rank_req.waddr      = cur_ff;
               rank_req.wdata.seen = 1'b0;
               rank_req.wdata.rank = idx_ff[ID_W-1:0];
               idx_in              = idx_ff + CNT_W'(1);
               state_in            = ST_SWP_CHK;
            end else begin
               last_in        = slot_rdata;
               slot_req.we    = 1'b1;
               slot_req.waddr = idx_ff[ID_W-1:0];
               slot_req.wdata = slot_rdata;
               rank_req.raddr = slot_rdata;
               count_in       = count_dec;
               removed_in     = removed_ff + CNT_W'(1);
               state_in       = ST_SWP_MOVE;
            end
         end
         ST_SWP_MOVE: begin
            slot_req.we         = 1'b1;
            slot_req.waddr      = count_ff[ID_W-1:0];
            slot_req.wdata      = cur_ff;
            rank_req.we         = 1'b1;
            rank_req.waddr      = last_ff;
            rank_req.wdata.seen = rank_rdata.seen;
            rank_req.wdata.rank = idx_ff[ID_W-1:0];
            state_in            = ST_SWP_FIX;
         end
         ST_SWP_FIX: begin
            rank_req.we         = 1'b1;
            rank_req.waddr      = cur_ff;
            rank_req.wdata.seen = 1'b0;
            rank_req.wdata.rank = count_ff[ID_W-1:0];
            state_in            = ST_SWP_CHK;
         end
         ST_DONE: begin
            if (done_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         ptr_ff   <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ptr_ff   <= ptr_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      removed_ff   <= removed_in;
      id_ff        <= id_in;
      cur_ff       <= cur_in;
      last_ff      <= last_in;
      res_slot_ff  <= res_slot_in;
      res_newly_ff <= res_newly_in;
   end

endmodule
